@@ hdl/brg_pkg.sv @@
// ----------------------------------------------------------------------------
// brg_pkg: shared types and codes of the resource guard
// Item kinds, status codes and the controller-to-datapath command struct.
// ----------------------------------------------------------------------------
package brg_pkg;

   localparam int KIND_BITS   = 3;
   localparam int STATUS_BITS = 3;
   localparam int FIELD_BITS  = 8;
   localparam int NRES_MAX    = 3;

   localparam logic [KIND_BITS-1:0] KIND_STOCK   = 3'd0;
   localparam logic [KIND_BITS-1:0] KIND_CLAIM   = 3'd1;
   localparam logic [KIND_BITS-1:0] KIND_REQUEST = 3'd2;
   localparam logic [KIND_BITS-1:0] KIND_RELEASE = 3'd3;
   localparam logic [KIND_BITS-1:0] KIND_RETIRE  = 3'd4;

   localparam logic [STATUS_BITS-1:0] ST_OK          = 3'd0;
   localparam logic [STATUS_BITS-1:0] ST_EXCEED_NEED = 3'd1;
   localparam logic [STATUS_BITS-1:0] ST_EXCEED_FREE = 3'd2;
   localparam logic [STATUS_BITS-1:0] ST_UNSAFE      = 3'd3;
   localparam logic [STATUS_BITS-1:0] ST_EXCEED_HELD = 3'd4;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;       // capture the input item
      logic apply;      // apply a simple item (stock, claim, release, retire)
      logic tentative;  // apply a request tentatively and start the check
      logic scan_start; // reset scan index and progress flag, start a pass
      logic scan_step;  // examine one customer
      logic rollback;   // undo a tentative grant
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic exceed_need;
      logic exceed_free;
      logic exceed_held;
      logic cust_valid;
      logic last_cust;
      logic progress;
      logic all_done;
   } stat_type;

endpackage

@@ hdl/brg_datapath.sv @@
// ----------------------------------------------------------------------------
// brg_datapath: tables and safety-check unit
// Holds free units, held and need tables, and steps the safety scan one
// customer per cycle under controller command.
// ----------------------------------------------------------------------------
module brg_datapath #(
   parameter int CUSTOMERS = 8,
   parameter int RESOURCES = 3,
   parameter int UNIT_BITS = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  brg_pkg::cmd_type                cmd,
   output brg_pkg::stat_type               stat,
   input  logic [brg_pkg::KIND_BITS-1:0]   in_kind,
   input  logic [brg_pkg::KIND_BITS-1:0]   in_customer,
   input  logic [brg_pkg::FIELD_BITS-1:0]  in_amount [brg_pkg::NRES_MAX],
   output logic [brg_pkg::FIELD_BITS-1:0]  free_out [brg_pkg::NRES_MAX]
);
   import brg_pkg::*;

   localparam int CB = (CUSTOMERS > 1) ? $clog2(CUSTOMERS) : 1;
   localparam logic [UNIT_BITS-1:0] UMAX = {UNIT_BITS{1'b1}};

   logic [UNIT_BITS-1:0] free_ff [RESOURCES];
   logic [UNIT_BITS-1:0] held_ff [CUSTOMERS][RESOURCES];
   logic [UNIT_BITS-1:0] need_ff [CUSTOMERS][RESOURCES];
   logic [UNIT_BITS-1:0] work_ff [RESOURCES];
   logic [UNIT_BITS-1:0] save_held_ff [RESOURCES];
   logic [UNIT_BITS-1:0] save_need_ff [RESOURCES];
   logic [UNIT_BITS-1:0] save_free_ff [RESOURCES];
   logic [UNIT_BITS-1:0] amt_ff [RESOURCES];
   logic [KIND_BITS-1:0] kind_ff;
   logic [CB-1:0]        cust_ff;
   logic                 cvalid_ff;
   logic [CUSTOMERS-1:0] done_ff;
   logic [CB-1:0]        scan_ff;
   logic                 prog_ff;

   function automatic logic [UNIT_BITS-1:0] sat_add(input logic [UNIT_BITS-1:0] a,
                                                     input logic [UNIT_BITS-1:0] b);
      logic [UNIT_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[UNIT_BITS] ? UMAX : s[UNIT_BITS-1:0];
   endfunction

   logic en, eh, ef, fits;
   always_comb begin
      en = 1'b0; ef = 1'b0; eh = 1'b0; fits = 1'b1;
      for (int r = 0; r < RESOURCES; r++) begin
         if (amt_ff[r] > need_ff[cust_ff][r]) en = 1'b1;
         if (amt_ff[r] > free_ff[r]) ef = 1'b1;
         if (amt_ff[r] > held_ff[cust_ff][r]) eh = 1'b1;
         if (need_ff[scan_ff][r] > work_ff[r]) fits = 1'b0;
      end
   end

   logic hit;
   assign hit = cmd.scan_step && !done_ff[scan_ff] && fits;

   assign stat.exceed_need = en;
   assign stat.exceed_free = ef;
   assign stat.exceed_held = eh;
   assign stat.cust_valid  = cvalid_ff;
   assign stat.last_cust   = (32'(scan_ff) == CUSTOMERS - 1);
   assign stat.progress    = prog_ff;
   assign stat.all_done    = &done_ff;

   always_comb begin
      for (int r = 0; r < NRES_MAX; r++) begin
         free_out[r] = '0;
         if (r < RESOURCES) free_out[r] = FIELD_BITS'(free_ff[r]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < RESOURCES; r++) begin
            free_ff[r] <= '0;
            work_ff[r] <= '0;
            for (int c = 0; c < CUSTOMERS; c++) begin
               held_ff[c][r] <= '0;
               need_ff[c][r] <= '0;
            end
         end
         done_ff <= '0;
         scan_ff <= '0;
         prog_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            kind_ff   <= in_kind;
            cust_ff   <= CB'(in_customer);
            cvalid_ff <= (32'(in_customer) < CUSTOMERS);
            for (int r = 0; r < RESOURCES; r++) amt_ff[r] <= UNIT_BITS'(in_amount[r]);
         end
         if (cmd.apply) begin
            for (int r = 0; r < RESOURCES; r++) begin
               case (kind_ff)
                  KIND_STOCK:   free_ff[r] <= sat_add(free_ff[r], amt_ff[r]);
                  KIND_CLAIM:   need_ff[cust_ff][r] <= amt_ff[r];
                  KIND_RETIRE:  need_ff[cust_ff][r] <= '0;
                  KIND_RELEASE: begin
                     held_ff[cust_ff][r] <= held_ff[cust_ff][r] - amt_ff[r];
                     free_ff[r] <= sat_add(free_ff[r], amt_ff[r]);
                     need_ff[cust_ff][r] <= sat_add(need_ff[cust_ff][r], amt_ff[r]);
                  end
                  default: ;
               endcase
            end
         end
         if (cmd.tentative) begin
            for (int r = 0; r < RESOURCES; r++) begin
               save_held_ff[r] <= held_ff[cust_ff][r];
               save_need_ff[r] <= need_ff[cust_ff][r];
               save_free_ff[r] <= free_ff[r];
               held_ff[cust_ff][r] <= sat_add(held_ff[cust_ff][r], amt_ff[r]);
               need_ff[cust_ff][r] <= need_ff[cust_ff][r] - amt_ff[r];
               free_ff[r] <= free_ff[r] - amt_ff[r];
               work_ff[r] <= free_ff[r] - amt_ff[r];
            end
            done_ff <= '0;
            scan_ff <= '0;
            prog_ff <= 1'b0;
         end
         if (cmd.scan_start) begin
            scan_ff <= '0;
            prog_ff <= 1'b0;
         end
         if (cmd.scan_step) begin
            if (hit) begin
               for (int r = 0; r < RESOURCES; r++)
                  work_ff[r] <= sat_add(work_ff[r], held_ff[scan_ff][r]);
               done_ff[scan_ff] <= 1'b1;
               prog_ff <= 1'b1;
            end
            scan_ff <= scan_ff + CB'(1);
         end
         if (cmd.rollback) begin
            for (int r = 0; r < RESOURCES; r++) begin
               held_ff[cust_ff][r] <= save_held_ff[r];
               need_ff[cust_ff][r] <= save_need_ff[r];
               free_ff[r] <= save_free_ff[r];
            end
         end
      end
   end

endmodule

@@ hdl/brg_controller.sv @@
// ----------------------------------------------------------------------------
// brg_controller: sequencer of the resource guard
// Accepts one item, runs checks and the safety scan, and holds the result
// in an output register until it is taken.
// ----------------------------------------------------------------------------
module brg_controller (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic [brg_pkg::KIND_BITS-1:0]     in_kind,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic                              out_granted,
   output logic [brg_pkg::STATUS_BITS-1:0]   out_status,
   output brg_pkg::cmd_type                  cmd,
   input  brg_pkg::stat_type                 stat
);
   import brg_pkg::*;

   typedef enum logic [2:0] {S_IDLE, S_DECIDE, S_SCAN, S_PASS, S_FINISH, S_DONE}
      state_type;

   state_type            state_ff, state_in;
   logic [KIND_BITS-1:0] kind_ff, kind_in;
   logic                 valid_ff, valid_in;
   logic                 grant_ff, grant_in;
   logic [STATUS_BITS-1:0] status_ff, status_in;

   assign in_ready    = (state_ff == S_IDLE) && !valid_ff;
   assign out_valid   = valid_ff;
   assign out_granted = grant_ff;
   assign out_status  = status_ff;

   always_comb begin
      state_in = state_ff; kind_in = kind_ff; valid_in = valid_ff;
      grant_in = grant_ff; status_in = status_ff;
      cmd = '0;
      if (valid_ff && out_ready) valid_in = 1'b0;
      unique case (state_ff)
         S_IDLE: if (in_valid && in_ready) begin
            cmd.load = 1'b1; kind_in = in_kind; state_in = S_DECIDE;
         end
         S_DECIDE: begin
            grant_in = 1'b0; status_in = ST_OK; state_in = S_DONE;
            if (kind_ff == KIND_STOCK) begin
               cmd.apply = 1'b1; grant_in = 1'b1;
            end else if (stat.cust_valid) begin
               case (kind_ff)
                  KIND_CLAIM, KIND_RETIRE: begin
                     cmd.apply = 1'b1; grant_in = 1'b1;
                  end
                  KIND_RELEASE:
                     if (stat.exceed_held) status_in = ST_EXCEED_HELD;
                     else begin cmd.apply = 1'b1; grant_in = 1'b1; end
                  KIND_REQUEST:
                     if (stat.exceed_need) status_in = ST_EXCEED_NEED;
                     else if (stat.exceed_free) status_in = ST_EXCEED_FREE;
                     else begin cmd.tentative = 1'b1; state_in = S_SCAN; end
                  default: ;
               endcase
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.last_cust) state_in = S_PASS;
         end
         S_PASS: begin
            if (stat.all_done || !stat.progress) state_in = S_FINISH;
            else begin cmd.scan_start = 1'b1; state_in = S_SCAN; end
         end
         S_FINISH: begin
            state_in = S_DONE;
            if (stat.all_done) begin grant_in = 1'b1; status_in = ST_OK; end
            else begin cmd.rollback = 1'b1; grant_in = 1'b0; status_in = ST_UNSAFE; end
         end
         S_DONE: begin valid_in = 1'b1; state_in = S_IDLE; end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in; valid_ff <= valid_in;
      end
      kind_ff <= kind_in; grant_ff <= grant_in; status_ff <= status_in;
   end

endmodule

@@ hdl/bankers_resource_guard.sv @@
// ----------------------------------------------------------------------------
// bankers_resource_guard: deadlock-avoiding resource guard
// Banker's safety check over per-customer held and need tables.
// ----------------------------------------------------------------------------
// Items arrive on the req_ stream: tdata carries kind, customer and three
// amounts; each item yields one transfer on the rsp_ stream with granted,
// status and the free units after the item.
// Stock, claim, release, retire and refused items go from the decide state
// straight to the done state, which raises rsp_tvalid. A request that
// reaches the safety check runs 1 to CUSTOMERS scan passes, with a pass
// check after each; the scan examines one customer per cycle. A finish
// state then grants or rolls back before the done state.
// One item is in work at a time; req_tready is low while an item is in
// work or a result waits. A stalled rsp_ side holds the result stable.
// Reset clears free units, all tables and the handshake state at once.
module bankers_resource_guard #(
   parameter int CUSTOMERS = 8,
   parameter int RESOURCES = 3,
   parameter int UNIT_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // kind[2:0], customer[5:3], amount_0[13:6], amount_1[21:14], amount_2[29:22]
   input  logic [31:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // granted[0], status[3:1], free_0[11:4], free_1[19:12], free_2[27:20]
   output logic [31:0] rsp_tdata
);
   import brg_pkg::*;

   cmd_type  cmd;
   stat_type stat;
   logic [FIELD_BITS-1:0] amount [NRES_MAX];
   logic [FIELD_BITS-1:0] free_v [NRES_MAX];
   logic                  granted;
   logic [STATUS_BITS-1:0] status;

   assign amount[0] = req_tdata[13:6];
   assign amount[1] = req_tdata[21:14];
   assign amount[2] = req_tdata[29:22];

   brg_controller u_ctrl (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready), .in_kind(req_tdata[2:0]),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_granted(granted), .out_status(status), .cmd, .stat
   );

   brg_datapath #(.CUSTOMERS(CUSTOMERS), .RESOURCES(RESOURCES), .UNIT_BITS(UNIT_BITS))
   u_dp (
      .clock, .reset, .cmd, .stat,
      .in_kind(req_tdata[2:0]), .in_customer(req_tdata[5:3]),
      .in_amount(amount), .free_out(free_v)
   );

   assign rsp_tdata = {4'b0, free_v[2], free_v[1], free_v[0], status, granted};

endmodule

@@ hdl/brg_checker.sv @@
// ----------------------------------------------------------------------------
// brg_checker: port-level checks of the resource guard
// Watches the stream ports and is bound to the top level.
// ----------------------------------------------------------------------------
module brg_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [31:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");
   a_no_accept_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("input taken while a result waits");
   a_accept_blocks: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready && !rsp_tvalid)
      else $error("item not held in work");
   a_grant_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[3:1] == 3'd0)
      else $error("granted with nonzero status");
endmodule

bind bankers_resource_guard brg_checker u_brg_checker (.*);

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb: self-checking bench of the banker's resource guard
// Drives stock, claim, request, release and retire items with random bursts
// and output stalls, predicts every result and compares it field by field.
// ----------------------------------------------------------------------------
module tb;
   import brg_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NCUST     = 8;
   localparam int NRES      = 3;
   localparam int UMAX      = 255;
   localparam int IDLE_LIMIT = 5000;

   typedef struct packed {
      logic [7:0]             free_2;
      logic [7:0]             free_1;
      logic [7:0]             free_0;
      logic [STATUS_BITS-1:0] status;
      logic                   granted;
   } grant_result_type;

   // Scoreboard: keeps a copy of the guard's tables and the queue of
   // results it owes.
   class guard_scoreboard;
      int unsigned free_u[NRES];
      int unsigned held[NCUST][NRES];
      int unsigned need[NCUST][NRES];
      grant_result_type owed_q[$];
      int errors;
      int grants;
      int refusals;

      function new();
         errors = 0;
         grants = 0;
         refusals = 0;
         foreach (free_u[r]) free_u[r] = 0;
         foreach (held[c, r]) begin
            held[c][r] = 0;
            need[c][r] = 0;
         end
      endfunction

      function int unsigned sat(int unsigned a, int unsigned b);
         return (a + b > UMAX) ? UMAX : a + b;
      endfunction

      function bit is_safe();
         int unsigned work[NRES];
         bit done[NCUST];
         int finished;
         bit progress;
         bit fits;
         finished = 0;
         progress = 1;
         foreach (work[r]) work[r] = free_u[r];
         foreach (done[c]) done[c] = 0;
         while (progress && finished < NCUST) begin
            progress = 0;
            for (int c = 0; c < NCUST; c++) begin
               if (!done[c]) begin
                  fits = 1;
                  for (int r = 0; r < NRES; r++)
                     if (need[c][r] > work[r]) fits = 0;
                  if (fits) begin
                     for (int r = 0; r < NRES; r++) work[r] = sat(work[r], held[c][r]);
                     done[c] = 1;
                     finished++;
                     progress = 1;
                  end
               end
            end
         end
         return finished == NCUST;
      endfunction

      function void note_item(logic [31:0] data);
         logic [2:0] kind;
         int unsigned cust;
         int unsigned amt[NRES];
         grant_result_type res;
         kind = data[2:0];
         cust = data[5:3];
         amt[0] = data[13:6];
         amt[1] = data[21:14];
         amt[2] = data[29:22];
         res = '0;
         if (kind == KIND_STOCK) begin
            for (int r = 0; r < NRES; r++) free_u[r] = sat(free_u[r], amt[r]);
            res.granted = 1;
         end else if (kind == KIND_CLAIM) begin
            for (int r = 0; r < NRES; r++) need[cust][r] = amt[r];
            res.granted = 1;
         end else if (kind == KIND_REQUEST) begin
            res.status = ST_OK;
            for (int r = 0; r < NRES; r++)
               if (amt[r] > need[cust][r]) res.status = ST_EXCEED_NEED;
            if (res.status == ST_OK)
               for (int r = 0; r < NRES; r++)
                  if (amt[r] > free_u[r]) res.status = ST_EXCEED_FREE;
            if (res.status == ST_OK) begin
               int unsigned sh[NRES];
               for (int r = 0; r < NRES; r++) begin
                  sh[r] = held[cust][r];
                  held[cust][r] = sat(held[cust][r], amt[r]);
                  need[cust][r] -= amt[r];
                  free_u[r] -= amt[r];
               end
               if (is_safe()) begin
                  res.granted = 1;
               end else begin
                  res.status = ST_UNSAFE;
                  for (int r = 0; r < NRES; r++) begin
                     held[cust][r] = sh[r];
                     need[cust][r] += amt[r];
                     free_u[r] += amt[r];
                  end
               end
            end
            if (res.granted) grants++;
            else refusals++;
         end else if (kind == KIND_RELEASE) begin
            for (int r = 0; r < NRES; r++)
               if (amt[r] > held[cust][r]) res.status = ST_EXCEED_HELD;
            if (res.status == ST_OK) begin
               for (int r = 0; r < NRES; r++) begin
                  held[cust][r] -= amt[r];
                  free_u[r] = sat(free_u[r], amt[r]);
                  need[cust][r] = sat(need[cust][r], amt[r]);
               end
               res.granted = 1;
            end
         end else if (kind == KIND_RETIRE) begin
            for (int r = 0; r < NRES; r++) need[cust][r] = 0;
            res.granted = 1;
         end
         res.free_0 = 8'(free_u[0]);
         res.free_1 = 8'(free_u[1]);
         res.free_2 = 8'(free_u[2]);
         owed_q.push_back(res);
      endfunction

      function void check_result(logic [31:0] data);
         grant_result_type got;
         grant_result_type want;
         got = data[27:0];
         if (data[31:28] !== 4'b0) begin
            $display("%0t: padding bits expected 0 actual %h", $time, data[31:28]);
            errors++;
         end
         if (owed_q.size() == 0) begin
            $display("%0t: unexpected result, expected none actual %h", $time, got);
            errors++;
            return;
         end
         want = owed_q.pop_front();
         if (got.granted !== want.granted) begin
            $display("%0t: granted expected %0d actual %0d", $time, want.granted, got.granted);
            errors++;
         end
         if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            errors++;
         end
         if (got.free_0 !== want.free_0) begin
            $display("%0t: free_0 expected %0d actual %0d", $time, want.free_0, got.free_0);
            errors++;
         end
         if (got.free_1 !== want.free_1) begin
            $display("%0t: free_1 expected %0d actual %0d", $time, want.free_1, got.free_1);
            errors++;
         end
         if (got.free_2 !== want.free_2) begin
            $display("%0t: free_2 expected %0d actual %0d", $time, want.free_2, got.free_2);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [31:0] rsp_tdata;

   guard_scoreboard sb = new();
   int  idle_cycles = 0;
   int  sent = 0;
   bit  long_hold = 0;
   bit  hold_asked = 0;
   bit  mid_drained = 0;

   always #10 clock = ~clock;

   bankers_resource_guard u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   // Sample both channels at the rising edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_item(req_tdata);
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // Receiver: own stall pattern, with one long hold-off on request.
   initial begin
      int mode;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (long_hold) begin
            rsp_tready <= 0;
            repeat (400) @(negedge clock);
            long_hold = 0;
         end
         mode = $urandom_range(0, 3);
         repeat ($urandom_range(5, 60)) begin
            case (mode)
               0: rsp_tready <= 1;
               1: rsp_tready <= ($urandom_range(0, 3) != 0);
               2: rsp_tready <= ($urandom_range(0, 1) != 0);
               default: rsp_tready <= ($urandom_range(0, 5) == 0);
            endcase
            @(negedge clock);
         end
      end
   end

   // Offers one item and holds it until the transfer.
   task automatic send_item(logic [2:0] kind, logic [2:0] cust,
                            logic [7:0] a0, logic [7:0] a1, logic [7:0] a2);
      req_tdata  <= {2'b00, a2, a1, a0, cust, kind};
      req_tvalid <= 1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      sent++;
   endtask

   task automatic idle_gap(int n);
      req_tvalid <= 0;
      repeat (n) @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (sb.owed_q.size() != 0) @(negedge clock);
   endtask

   // Amount that is mostly small and legal-looking, sometimes wide open.
   function automatic logic [7:0] pick_amt(int unsigned limit);
      if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
      if (limit == 0) return 0;
      return 8'($urandom_range(0, limit));
   endfunction

   initial begin
      logic [2:0] cust;
      int burst;
      repeat (10) @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // Directed: saturation of stock, every kind, need and held refusals, reserved kinds.
      send_item(KIND_STOCK, 0, 8'd255, 8'd0, 8'd128);
      send_item(KIND_STOCK, 5, 8'd10, 8'd255, 8'd200);
      send_item(KIND_CLAIM, 0, 8'd255, 8'd255, 8'd255);
      send_item(KIND_REQUEST, 1, 8'd1, 8'd0, 8'd0);
      send_item(KIND_CLAIM, 1, 8'd5, 8'd5, 8'd5);
      send_item(KIND_REQUEST, 1, 8'd5, 8'd5, 8'd5);
      send_item(KIND_REQUEST, 0, 8'd200, 8'd200, 8'd200);
      send_item(KIND_REQUEST, 0, 8'd255, 8'd0, 8'd0);
      send_item(KIND_RELEASE, 1, 8'd6, 8'd0, 8'd0);
      send_item(KIND_RELEASE, 1, 8'd5, 8'd5, 8'd5);
      send_item(KIND_RETIRE, 0, 8'd0, 8'd0, 8'd0);
      send_item(KIND_CLAIM, 7, 8'd0, 8'd0, 8'd1);
      send_item(KIND_REQUEST, 7, 8'd0, 8'd0, 8'd1);
      send_item(KIND_STOCK, 2, 8'd255, 8'd255, 8'd255);
      send_item(KIND_RELEASE, 7, 8'd0, 8'd0, 8'd1);
      send_item(3'd5, 3, 8'd1, 8'd2, 8'd3);
      send_item(3'd6, 4, 8'd255, 8'd255, 8'd255);
      send_item(3'd7, 7, 8'd0, 8'd0, 8'd0);
      send_item(KIND_RETIRE, 7, 8'd255, 8'd255, 8'd255);
      send_item(KIND_CLAIM, 3, 8'd0, 8'd0, 8'd0);
      send_item(KIND_REQUEST, 3, 8'd0, 8'd0, 8'd0);
      drain();

      // Random: well-formed claim, request, release cycles with some noise.
      while (sent < 840) begin
         if (sent > 300 && !hold_asked) begin
            long_hold = 1;
            hold_asked = 1;
         end
         if (sent >= 500 && !mid_drained) begin
            drain();
            mid_drained = 1;
         end
         burst = $urandom_range(1, 20);
         repeat (burst) begin
            cust = 3'($urandom_range(0, NCUST - 1));
            case ($urandom_range(0, 19))
               0, 1:
                  send_item(KIND_STOCK, 3'($urandom), pick_amt(40), pick_amt(40),
                            pick_amt(40));
               2, 3, 4:
                  send_item(KIND_CLAIM, cust, pick_amt(60), pick_amt(60), pick_amt(60));
               5, 6, 7, 8, 9, 10, 11:
                  send_item(KIND_REQUEST, cust,
                            pick_amt(sb.need[cust][0]), pick_amt(sb.need[cust][1]),
                            pick_amt(sb.need[cust][2]));
               12, 13, 14, 15:
                  send_item(KIND_RELEASE, cust,
                            pick_amt(sb.held[cust][0]), pick_amt(sb.held[cust][1]),
                            pick_amt(sb.held[cust][2]));
               16:
                  send_item(KIND_RETIRE, cust, 8'($urandom), 8'($urandom), 8'($urandom));
               17:
                  send_item(3'($urandom_range(5, 7)), cust, 8'($urandom), 8'($urandom),
                            8'($urandom));
               default:
                  send_item(3'($urandom), 3'($urandom), 8'($urandom), 8'($urandom),
                            8'($urandom));
            endcase
         end
         if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 40));
      end

      drain();
      repeat (100) @(negedge clock);
      $display("Sent %0d items; %0d requests granted, %0d refused.",
               sent, sb.grants, sb.refusals);
      $display("Covered saturation, all refusal codes, reserved kinds and stalls.");
      if (sb.errors == 0 && sb.owed_q.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule
